// ----- hw/rtl/kmpd_pkg.sv -----
// Shared types and constants of the keyboard and mouse packet decoder.
package kmpd_pkg;

	// Payload widths
	localparam int CMD_W    = 3;
	localparam int BYTE_W   = 8;
	localparam int POS_X_W  = 10;
	localparam int POS_Y_W  = 9;
	localparam int CFG_DW   = 10;
	localparam int CFG_IW   = 3;

	// Register reset values
	localparam logic [POS_X_W-1:0] MAX_X_RST        = 10'd620;
	localparam logic [POS_Y_W-1:0] MAX_Y_RST        = 9'd380;
	localparam logic [POS_X_W-1:0] START_X_RST      = 10'd320;
	localparam logic [POS_Y_W-1:0] START_Y_RST      = 9'd200;
	localparam logic [BYTE_W-1:0]  HEADER_CODE_RST  = 8'd248;
	localparam logic [BYTE_W-1:0]  LEFT_CODE_RST    = 8'd250;
	localparam logic [BYTE_W-1:0]  RELEASE_MASK_RST = 8'h80;
	localparam logic [BYTE_W-1:0]  NO_KEY           = 8'h00;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_BYTE  = 3'd0,
		CMD_APPLY = 3'd1,
		CMD_POP   = 3'd2,
		CMD_CLEAR = 3'd3,
		CMD_INIT  = 3'd4
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [CFG_IW-1:0] {
		REG_MAX_X        = 3'd0,
		REG_MAX_Y        = 3'd1,
		REG_START_X      = 3'd2,
		REG_START_Y      = 3'd3,
		REG_HEADER_CODE  = 3'd4,
		REG_LEFT_CODE    = 3'd5,
		REG_RELEASE_MASK = 3'd6
	} cfg_reg_t;

	// Mouse packet phase
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DX     = 2'd1,
		PH_DY     = 2'd2
	} phase_t;

endpackage

// ----- hw/rtl/kmpd_if.sv -----
// Handshake channels of the decoder: command words in, status words out.
interface kmpd_req_if;
	logic                        valid;
	logic                        ready;
	logic [kmpd_pkg::CMD_W-1:0]  cmd;
	logic [kmpd_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface kmpd_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         key_valid;
	logic [kmpd_pkg::BYTE_W-1:0]  key_code;
	logic                         keys_waiting;
	logic [kmpd_pkg::POS_X_W-1:0] pos_x;
	logic [kmpd_pkg::POS_Y_W-1:0] pos_y;
	logic                         left_click;
	logic                         moved_flag;

	modport source (output valid, output key_valid, output key_code, output keys_waiting,
		output pos_x, output pos_y, output left_click, output moved_flag, input ready);
	modport sink   (input valid, input key_valid, input key_code, input keys_waiting,
		input pos_x, input pos_y, input left_click, input moved_flag, output ready);
endinterface

// ----- hw/rtl/kbd_mouse_packet_decoder_core.sv -----
// Keyboard byte stream and relative mouse packet decoder with a key ring memory.
// Each accepted command word loads its status word into the output register.
// Throughput: one word per cycle while no status word is pending or rsp.ready is high; the key ring
// is a one-port-write, one-port-read memory whose registered read data lands together with the status word.
// Reset: arst_n clears pointers, packet phase, mouse state and loads register
// defaults at once; the key ring contents are not cleared and need no sweep.
module kbd_mouse_packet_decoder_core #(
	parameter int KEY_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	kmpd_req_if.sink                     req,
	kmpd_rsp_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic [kmpd_pkg::CFG_IW-1:0]  cfg_idx,
	input  logic [kmpd_pkg::CFG_DW-1:0]  cfg_data
);
	import kmpd_pkg::*;

	localparam int PW = $clog2(2 * KEY_DEPTH);
	localparam int AW = $clog2(KEY_DEPTH);
	localparam logic [PW-1:0] DEPTH_P = PW'(KEY_DEPTH);
	localparam logic [PW-1:0] WRAP_P  = PW'(2 * KEY_DEPTH - 1);
	localparam logic [PW:0]   SPAN_P  = (PW+1)'(2 * KEY_DEPTH);

	// Advance a ring pointer modulo twice the depth
	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == WRAP_P) ? '0 : p + PW'(1);
	endfunction

	// Map a ring pointer to a memory address
	function automatic logic [AW-1:0] ptr_addr(input logic [PW-1:0] p);
		logic [PW-1:0] q;
		q = (p >= DEPTH_P) ? p - DEPTH_P : p;
		return q[AW-1:0];
	endfunction

	// Entries held between two pointers
	function automatic logic [PW-1:0] ptr_fill(input logic [PW-1:0] w, input logic [PW-1:0] r);
		logic [PW:0] s;
		s = {1'b0, w} + SPAN_P - {1'b0, r};
		return (w >= r) ? w - r : s[PW-1:0];
	endfunction

	// Configuration registers
	logic [POS_X_W-1:0] max_x_q, start_x_q;
	logic [POS_Y_W-1:0] max_y_q, start_y_q;
	logic [BYTE_W-1:0]  header_code_q, left_code_q, release_mask_q;

	// Decoder state
	phase_t             phase_q, phase_nxt;
	logic [BYTE_W-1:0]  button_q, button_nxt;
	logic [BYTE_W-1:0]  dx_q, dx_nxt, dy_q, dy_nxt;
	logic               moved_q, moved_nxt, click_q, click_nxt;
	logic [POS_X_W-1:0] px_q, px_nxt;
	logic [POS_Y_W-1:0] py_q, py_nxt;
	logic [PW-1:0]      rd_ptr_q, rd_ptr_nxt, wr_ptr_q, wr_ptr_nxt;

	// Key ring memory and its ports
	logic [BYTE_W-1:0]  ring_mem [KEY_DEPTH];
	logic [BYTE_W-1:0]  rd_data_q;
	logic               mem_we, pop_hit;

	// Output stage
	logic               rsp_valid_q, kv_q, waiting_q;

	logic               accept;
	cmd_t               cmd;
	logic [PW-1:0]      fill_cur;
	logic               ring_full, is_make;
	logic signed [POS_X_W+1:0] sum_x;
	logic signed [POS_Y_W+1:0] sum_y;
	logic [POS_X_W-1:0] clamp_x;
	logic [POS_Y_W-1:0] clamp_y;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign cmd       = cmd_t'(req.cmd);
	assign fill_cur  = ptr_fill(wr_ptr_q, rd_ptr_q);
	assign ring_full = (fill_cur == DEPTH_P);
	assign is_make   = ((req.rx_byte & release_mask_q) == '0);

	// Apply signed deltas and clamp to 0..max
	always_comb begin
		sum_x = $signed({2'b00, px_q}) + (POS_X_W+2)'($signed(dx_q));
		sum_y = $signed({2'b00, py_q}) + (POS_Y_W+2)'($signed(dy_q));
		if (sum_x < 0) begin
			clamp_x = '0;
		end else if (sum_x > $signed({2'b00, max_x_q})) begin
			clamp_x = max_x_q;
		end else begin
			clamp_x = sum_x[POS_X_W-1:0];
		end
		if (sum_y < 0) begin
			clamp_y = '0;
		end else if (sum_y > $signed({2'b00, max_y_q})) begin
			clamp_y = max_y_q;
		end else begin
			clamp_y = sum_y[POS_Y_W-1:0];
		end
	end

	// Decode the command word into next state
	always_comb begin
		phase_nxt  = phase_q;
		button_nxt = button_q;
		dx_nxt     = dx_q;
		dy_nxt     = dy_q;
		moved_nxt  = moved_q;
		click_nxt  = click_q;
		px_nxt     = px_q;
		py_nxt     = py_q;
		rd_ptr_nxt = rd_ptr_q;
		wr_ptr_nxt = wr_ptr_q;
		mem_we     = 1'b0;
		pop_hit    = 1'b0;
		unique case (cmd)
			CMD_BYTE: begin
				unique case (phase_q)
					PH_DX: begin
						dx_nxt    = req.rx_byte;
						phase_nxt = PH_DY;
					end
					PH_DY: begin
						dy_nxt    = req.rx_byte;
						phase_nxt = PH_HEADER;
					end
					default: begin
						if (req.rx_byte >= header_code_q) begin
							button_nxt = req.rx_byte;
							moved_nxt  = (req.rx_byte == header_code_q);
							phase_nxt  = PH_DX;
						end else if (is_make && !ring_full) begin
							mem_we     = 1'b1;
							wr_ptr_nxt = ptr_inc(wr_ptr_q);
						end
					end
				endcase
			end
			CMD_APPLY: begin
				px_nxt    = clamp_x;
				py_nxt    = clamp_y;
				click_nxt = (button_q == left_code_q);
				dx_nxt    = '0;
				dy_nxt    = '0;
			end
			CMD_POP: begin
				if (fill_cur != '0) begin
					pop_hit    = 1'b1;
					rd_ptr_nxt = ptr_inc(rd_ptr_q);
				end
			end
			CMD_CLEAR: begin
				rd_ptr_nxt = wr_ptr_q;
			end
			CMD_INIT: begin
				px_nxt = start_x_q;
				py_nxt = start_y_q;
			end
			default: begin
			end
		endcase
	end

	// Write pushes and read the head entry; one word never both pushes and pops
	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			ring_mem[ptr_addr(wr_ptr_q)] <= req.rx_byte;
		end
		if (accept) begin
			rd_data_q <= ring_mem[ptr_addr(rd_ptr_q)];
		end
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q        <= MAX_X_RST;
			max_y_q        <= MAX_Y_RST;
			start_x_q      <= START_X_RST;
			start_y_q      <= START_Y_RST;
			header_code_q  <= HEADER_CODE_RST;
			left_code_q    <= LEFT_CODE_RST;
			release_mask_q <= RELEASE_MASK_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_MAX_X:        max_x_q        <= cfg_data;
				REG_MAX_Y:        max_y_q        <= cfg_data[POS_Y_W-1:0];
				REG_START_X:      start_x_q      <= cfg_data;
				REG_START_Y:      start_y_q      <= cfg_data[POS_Y_W-1:0];
				REG_HEADER_CODE:  header_code_q  <= cfg_data[BYTE_W-1:0];
				REG_LEFT_CODE:    left_code_q    <= cfg_data[BYTE_W-1:0];
				REG_RELEASE_MASK: release_mask_q <= cfg_data[BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Advance decoder state and load the status word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			button_q    <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			moved_q     <= 1'b0;
			click_q     <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			rsp_valid_q <= 1'b0;
			kv_q        <= 1'b0;
			waiting_q   <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				phase_q     <= phase_nxt;
				button_q    <= button_nxt;
				dx_q        <= dx_nxt;
				dy_q        <= dy_nxt;
				moved_q     <= moved_nxt;
				click_q     <= click_nxt;
				px_q        <= px_nxt;
				py_q        <= py_nxt;
				rd_ptr_q    <= rd_ptr_nxt;
				wr_ptr_q    <= wr_ptr_nxt;
				rsp_valid_q <= 1'b1;
				kv_q        <= pop_hit;
				waiting_q   <= (ptr_fill(wr_ptr_nxt, rd_ptr_nxt) != '0);
			end
		end
	end

	// Drive the status word
	assign rsp.valid        = rsp_valid_q;
	assign rsp.key_valid    = kv_q;
	assign rsp.key_code     = kv_q ? rd_data_q : NO_KEY;
	assign rsp.keys_waiting = waiting_q;
	assign rsp.pos_x        = px_q;
	assign rsp.pos_y        = py_q;
	assign rsp.left_click   = click_q;
	assign rsp.moved_flag   = moved_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_cur <= DEPTH_P)
		else $error("key ring fill exceeds depth");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_POP && fill_cur == '0) |=> !rsp.key_valid)
		else $error("pop of empty ring returned a key");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_CLEAR) |=> (!rsp.keys_waiting && rd_ptr_q == wr_ptr_q))
		else $error("clear left keys in the ring");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_BYTE && ring_full) |=> $stable(wr_ptr_q))
		else $error("push into full ring moved write pointer");
`endif

endmodule
